[design/tksl_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tksl_pkg
// Shared types and constants for the top-K sorted insertion list.
// ---------------------------------------------------------------------------
package tksl_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int SCORE_W    = 32;
  localparam int TAG_W      = 32;
  localparam int INDEX_W    = 4;
  localparam int POS_W      = 4;
  localparam int FILL_W     = 5;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int SLOT_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  // What one cell shows its successor: stored entry and insertion flag.
  typedef struct packed {
    logic                      flag;
    logic                      valid;
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
  } link_t;

endpackage
`default_nettype wire

[design/top_k_sorted_insert_list_top.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// top_k_sorted_insert_list_top
// Top-K list of score and tag, kept in descending score order by a row of
// comparing cells.
// ---------------------------------------------------------------------------
// A request is taken on any cycle with start high (busy is always low), so
// one request per clock is sustained. Each request gives exactly one result,
// shown with done high for a single cycle, in the cycle after the request is
// taken; the receiver cannot hold it off, so sample it on that cycle. The
// result comes from the single register stage behind the cell row: every
// cell compares its stored score against the new one in parallel and the
// whole list shifts in the same edge. An insert lands ahead of equal scores;
// a full list rejects a score below its last entry and otherwise drops its
// last entry. A read beyond the fill count returns read_valid low and zero
// data. fill_count reports the number of entries after the request.
// ---------------------------------------------------------------------------
module top_k_sorted_insert_list_top
  import tksl_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      operation,
  input  wire logic signed [SCORE_W-1:0] new_score,
  input  wire logic [TAG_W-1:0]          new_tag,
  input  wire logic [INDEX_W-1:0]        read_index,
  output logic                           done,
  output logic                           accepted,
  output logic [POS_W-1:0]               insert_position,
  output logic                           read_valid,
  output logic signed [SCORE_W-1:0]      read_score,
  output logic [TAG_W-1:0]               read_tag,
  output logic [FILL_W-1:0]              fill_count
);

  // link[i] feeds cell i; link[i+1] is what cell i shows
  link_t link [LIST_DEPTH+1];

  logic              take;
  logic              is_insert;
  logic              room;
  logic              insert_en;
  logic              full;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [SLOT_W-1:0] head_slot;

  logic                      rd_valid_sel;
  logic signed [SCORE_W-1:0] rd_score_sel;
  logic [TAG_W-1:0]          rd_tag_sel;

  // Every request completes without stalling; never hold off the sender.
  assign busy = 1'b0;

  assign take      = start && !busy;
  assign is_insert = (op_t'(operation) == OP_INSERT);

  // Last slot flags: empty, or its score not above the new one.
  assign room      = link[LIST_DEPTH].flag;
  assign insert_en = take && is_insert && room;
  assign full      = link[LIST_DEPTH].valid;

  // Head of the row: never flags, always counts as filled.
  assign link[0].flag  = 1'b0;
  assign link[0].valid = 1'b1;
  assign link[0].score = '0;
  assign link[0].tag   = '0;

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    tksl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .insert_en (insert_en),
      .new_score (new_score),
      .new_tag   (new_tag),
      .prev      (link[g]),
      .cur       (link[g+1])
    );
  end

  // Encode the one cell where the flag first rises.
  always_comb begin
    head_slot = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (link[i+1].flag && !link[i].flag) begin
        head_slot = head_slot | SLOT_W'(i);
      end
    end
  end

  // Select the addressed entry; slots past the fill read as invalid.
  always_comb begin
    rd_valid_sel = 1'b0;
    rd_score_sel = '0;
    rd_tag_sel   = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if ((int'(read_index) == i) && link[i+1].valid) begin
        rd_valid_sel = 1'b1;
        rd_score_sel = link[i+1].score;
        rd_tag_sel   = link[i+1].tag;
      end
    end
  end

  // Grow the fill count until the list is full.
  always_comb begin
    count_next = count;
    if (insert_en && !full) begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= take;
    end
  end

  // Result register: zero the fields that do not belong to the request.
  always_ff @(posedge clk) begin
    if (take) begin
      accepted        <= insert_en;
      insert_position <= insert_en ? POS_W'(head_slot) : '0;
      read_valid      <= !is_insert && rd_valid_sel;
      read_score      <= is_insert ? '0 : rd_score_sel;
      read_tag        <= is_insert ? '0 : rd_tag_sel;
      fill_count      <= FILL_W'(count_next);
    end
  end

endmodule
`default_nettype wire

[design/tksl_cell.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tksl_cell
// One list slot: holds an entry, flags whether a new score goes at or
// before it, and loads either the new entry or its neighbour's entry.
// ---------------------------------------------------------------------------
module tksl_cell
  import tksl_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      insert_en,
  input  wire logic signed [SCORE_W-1:0] new_score,
  input  wire logic [TAG_W-1:0]          new_tag,
  input  wire link_t                     prev,
  output link_t                          cur
);

  logic                      valid;
  logic signed [SCORE_W-1:0] score;
  logic [TAG_W-1:0]          tag;
  logic                      flag;

  // Empty slot or stored score not above the new one.
  assign flag = !valid || (score <= new_score);

  assign cur.flag  = flag;
  assign cur.valid = valid;
  assign cur.score = score;
  assign cur.tag   = tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (insert_en) begin
      if (prev.flag) begin
        valid <= prev.valid;
      end else if (flag) begin
        valid <= 1'b1;
      end
    end
  end

  // Shift down from the neighbour, or take the new entry at the head.
  always_ff @(posedge clk) begin
    if (insert_en) begin
      if (prev.flag) begin
        score <= prev.score;
        tag   <= prev.tag;
      end else if (flag) begin
        score <= new_score;
        tag   <= new_tag;
      end
    end
  end

endmodule
`default_nettype wire

[design/tksl_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tksl_checker
// Port-level checks on the top-K list: result timing and field exclusivity.
// ---------------------------------------------------------------------------
module tksl_checker
  import tksl_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      operation,
  input wire logic                      done,
  input wire logic                      accepted,
  input wire logic [POS_W-1:0]          insert_position,
  input wire logic                      read_valid,
  input wire logic signed [SCORE_W-1:0] read_score,
  input wire logic [TAG_W-1:0]          read_tag,
  input wire logic [FILL_W-1:0]         fill_count
);

  // One result in the cycle after each request, none otherwise.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without request");

  // A read never reports an accepted insert.
  a_fields_by_op: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op_t'(operation) == OP_READ)) |=> !accepted)
    else $error("read reported as accepted insert");

  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    (done && !read_valid) |-> (read_score == '0 && read_tag == '0))
    else $error("invalid read carries data");

  // Position lies inside the list held after the insert.
  a_pos_in_fill: assert property (@(posedge clk) disable iff (rst)
    (done && accepted) |-> (FILL_W'(insert_position) < fill_count))
    else $error("insert position beyond fill count");

endmodule

bind top_k_sorted_insert_list_top tksl_checker u_tksl_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .operation       (operation),
  .done            (done),
  .accepted        (accepted),
  .insert_position (insert_position),
  .read_valid      (read_valid),
  .read_score      (read_score),
  .read_tag        (read_tag),
  .fill_count      (fill_count)
);
`default_nettype wire

[verif/tb_top_k_sorted_insert_list_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top_k_sorted_insert_list_top
// Self-checking bench for the top-K sorted insertion list. A short table of
// directed requests is followed by three random phases with different
// sender idling. Every accepted request is run through a local model of the
// list, and each done strobe is checked field by field against the oldest
// outstanding prediction.
// ---------------------------------------------------------------------------
module tb_top_k_sorted_insert_list_top;
  import tksl_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 4;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // One result as the block reports it.
  typedef struct {
    logic                      accepted;
    logic [POS_W-1:0]          position;
    logic                      read_valid;
    logic signed [SCORE_W-1:0] read_score;
    logic [TAG_W-1:0]          read_tag;
    logic [FILL_W-1:0]         fill;
  } outcome_t;

  // A request, optionally carrying a result typed in by hand.
  typedef struct {
    op_t                       op;
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
    logic [INDEX_W-1:0]        index;
    bit                        pinned;
    outcome_t                  want;
  } stim_row_t;

  typedef struct {
    bit       pinned;
    outcome_t want;
  } pin_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic operation = 1'b0;
  logic signed [SCORE_W-1:0] new_score = '0;
  logic [TAG_W-1:0] new_tag = '0;
  logic [INDEX_W-1:0] read_index = '0;

  logic busy;
  logic done;
  logic accepted;
  logic [POS_W-1:0] insert_position;
  logic read_valid;
  logic signed [SCORE_W-1:0] read_score;
  logic [TAG_W-1:0] read_tag;
  logic [FILL_W-1:0] fill_count;

  // Local copy of the list, advanced on every accepted request.
  logic signed [SCORE_W-1:0] held_score [LIST_DEPTH];
  logic [TAG_W-1:0]          held_tag   [LIST_DEPTH];
  int                        held_count;

  outcome_t  pending_results[$];
  pin_t      pinned_results[$];
  stim_row_t directed_rows[$];

  int mismatch_count = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;

  top_k_sorted_insert_list_top dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .new_score       (new_score),
    .new_tag         (new_tag),
    .read_index      (read_index),
    .done            (done),
    .accepted        (accepted),
    .insert_position (insert_position),
    .read_valid      (read_valid),
    .read_score      (read_score),
    .read_tag        (read_tag),
    .fill_count      (fill_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      held_score[i] = '0;
      held_tag[i]   = '0;
    end
    held_count = 0;
  end

  // Apply one request to the local list and return what the block should
  // report. Inserts walk past strictly greater scores, so a new entry lands
  // ahead of equal ones; a full list drops its tail or rejects the request.
  function automatic outcome_t place_or_read(op_t op, logic signed [SCORE_W-1:0] score,
                                             logic [TAG_W-1:0] tag,
                                             logic [INDEX_W-1:0] index);
    outcome_t o;
    bit       full;
    int       slot;
    int       tail;
    o = '{default: '0};
    if (op == OP_INSERT) begin
      full = (held_count == LIST_DEPTH);
      if (!(full && held_score[LIST_DEPTH-1] > score)) begin
        slot = 0;
        while (slot < held_count && held_score[slot] > score)
          slot++;
        tail = full ? LIST_DEPTH - 1 : held_count;
        for (int i = tail; i > slot; i--) begin
          held_score[i] = held_score[i-1];
          held_tag[i]   = held_tag[i-1];
        end
        if (slot < LIST_DEPTH) begin
          held_score[slot] = score;
          held_tag[slot]   = tag;
        end
        if (!full)
          held_count++;
        o.accepted = 1'b1;
        o.position = slot[POS_W-1:0];
      end
    end else if (int'(index) < held_count) begin
      o.read_valid = 1'b1;
      o.read_score = held_score[index];
      o.read_tag   = held_tag[index];
    end
    o.fill = held_count[FILL_W-1:0];
    return o;
  endfunction

  function automatic outcome_t make_outcome(logic acc, logic [POS_W-1:0] pos, logic rv,
                                            logic signed [SCORE_W-1:0] rs,
                                            logic [TAG_W-1:0] rt, logic [FILL_W-1:0] fill);
    outcome_t o;
    o.accepted   = acc;
    o.position   = pos;
    o.read_valid = rv;
    o.read_score = rs;
    o.read_tag   = rt;
    o.fill       = fill;
    return o;
  endfunction

  function automatic stim_row_t make_row(op_t op, logic signed [SCORE_W-1:0] score,
                                         logic [TAG_W-1:0] tag, logic [INDEX_W-1:0] index);
    stim_row_t r;
    r.op     = op;
    r.score  = score;
    r.tag    = tag;
    r.index  = index;
    r.pinned = 1'b0;
    r.want   = '{default: '0};
    return r;
  endfunction

  function automatic stim_row_t pin_row(stim_row_t r, outcome_t o);
    stim_row_t p;
    p        = r;
    p.pinned = 1'b1;
    p.want   = o;
    return p;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t mismatch on %s: expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // Present one request, idling first at the current sender rate, and hold
  // it until the block takes it. The pin entry is queued before start rises,
  // so it is always in place when the monitor sees the handshake.
  task automatic send_request(input stim_row_t r);
    pin_t p;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    p.pinned = r.pinned;
    p.want   = r.want;
    pinned_results.push_back(p);
    start      <= 1'b1;
    operation  <= r.op;
    new_score  <= r.score;
    new_tag    <= r.tag;
    read_index <= r.index;
    do
      @(posedge clk);
    while (busy);
  endtask

  // Drop start and hold off until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  // Random requests: mostly inserts, with scores drawn so that equal scores,
  // extremes and near-zero clusters all turn up often.
  task automatic run_random(input int count);
    stim_row_t r;
    op_t       op;
    logic signed [SCORE_W-1:0] score;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_READ;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: score = $urandom;
        4, 5, 6:    score = $signed($urandom_range(0, 16)) - 8;
        7:          score = $urandom_range(0, 1) ? SCORE_MAX : SCORE_MIN;
        default: begin
          if (held_count > 0)
            score = held_score[$urandom_range(0, held_count - 1)];
          else
            score = $urandom;
        end
      endcase
      r = make_row(op, score, $urandom, INDEX_W'($urandom_range(0, 15)));
      send_request(r);
    end
  endtask

  // Monitor: check the strobed result first, then record any request taken
  // on this edge. Both look at values from before the edge.
  always @(posedge clk) begin : monitor
    outcome_t want;
    outcome_t got;
    pin_t     pin;
    if (!rst) begin
      quiet_cycles++;
      if (done === 1'b1) begin
        quiet_cycles = 0;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t result strobed with no request outstanding", $time);
        end else begin
          want = pending_results.pop_front();
          got  = make_outcome(accepted, insert_position, read_valid, read_score, read_tag,
                              fill_count);
          compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
          compare_field("insert_position", 32'(want.position), 32'(got.position));
          compare_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
          compare_field("read_score", want.read_score, got.read_score);
          compare_field("read_tag", want.read_tag, got.read_tag);
          compare_field("fill_count", 32'(want.fill), 32'(got.fill));
        end
      end
      if (start && !busy) begin
        quiet_cycles = 0;
        want = place_or_read(op_t'(operation), new_score, new_tag, read_index);
        if (pinned_results.size() != 0) begin
          pin = pinned_results.pop_front();
          if (pin.pinned)
            want = pin.want;
        end
        pending_results.push_back(want);
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no request or result for %0d cycles", $time, quiet_cycles);
        $display("FAIL top_k_sorted_insert_list_top");
        $finish;
      end
    end
  end

  initial begin : stimulus
    // Directed table. Rows with a typed result: reads of an empty list,
    // the first two inserts at the score extremes, a read past the fill,
    // and the reject and head insert on a full list.
    directed_rows.push_back(pin_row(make_row(OP_READ, '0, '0, 4'd0),
                                    make_outcome(1'b0, 4'd0, 1'b0, '0, '0, 5'd0)));
    directed_rows.push_back(pin_row(make_row(OP_READ, '0, '0, 4'd15),
                                    make_outcome(1'b0, 4'd0, 1'b0, '0, '0, 5'd0)));
    directed_rows.push_back(pin_row(make_row(OP_INSERT, SCORE_MAX, 32'hFFFF_FFFF, 4'd15),
                                    make_outcome(1'b1, 4'd0, 1'b0, '0, '0, 5'd1)));
    directed_rows.push_back(pin_row(make_row(OP_INSERT, SCORE_MIN, 32'h0000_0000, 4'd0),
                                    make_outcome(1'b1, 4'd1, 1'b0, '0, '0, 5'd2)));
    directed_rows.push_back(make_row(OP_INSERT, '0, 32'hA5A5_A5A5, 4'd0));
    // Equal score: lands ahead of the one just stored.
    directed_rows.push_back(make_row(OP_INSERT, '0, 32'h5A5A_5A5A, 4'd0));
    directed_rows.push_back(make_row(OP_READ, SCORE_MAX, 32'hFFFF_FFFF, 4'd1));
    directed_rows.push_back(pin_row(make_row(OP_READ, '0, '0, 4'd4),
                                    make_outcome(1'b0, 4'd0, 1'b0, '0, '0, 5'd4)));
    // Fill the list to depth with spread-out scores.
    for (int k = 0; k < LIST_DEPTH - 4; k++)
      directed_rows.push_back(make_row(OP_INSERT, k * 7919 - 40000, 32'h1000_0000 + k,
                                       4'(k)));
    directed_rows.push_back(make_row(OP_READ, '0, '0, 4'd15));
    // Full list, score equal to the tail: taken at the last slot.
    directed_rows.push_back(make_row(OP_INSERT, SCORE_MIN, 32'h1234_5678, 4'd0));
    // Full list: push the minimum off the tail.
    directed_rows.push_back(make_row(OP_INSERT, 1, 32'h8765_4321, 4'd0));
    // Full list, score below the tail: rejected, list unchanged.
    directed_rows.push_back(pin_row(make_row(OP_INSERT, SCORE_MIN, 32'hDEAD_BEEF, 4'd0),
                                    make_outcome(1'b0, 4'd0, 1'b0, '0, '0, 5'd16)));
    // Full list, maximum score equal to the head: taken at the top.
    directed_rows.push_back(pin_row(make_row(OP_INSERT, SCORE_MAX, 32'h0000_0000, 4'd0),
                                    make_outcome(1'b1, 4'd0, 1'b0, '0, '0, 5'd16)));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    sender_idle_pct = 22;
    foreach (directed_rows[i])
      send_request(directed_rows[i]);
    drain_results();

    // Random phases: sender idles now and then, then often, then never.
    // Hold off between phases until the block has returned everything.
    sender_idle_pct = 22;
    run_random(250);
    drain_results();
    sender_idle_pct = 68;
    run_random(250);
    drain_results();
    sender_idle_pct = 0;
    run_random(250);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatch_count += pending_results.size();
      $display("%0t %0d expected results never arrived", $time, pending_results.size());
    end
    if (mismatch_count == 0)
      $display("PASS top_k_sorted_insert_list_top");
    else
      $display("FAIL top_k_sorted_insert_list_top");
    $finish;
  end

endmodule
